>>> design/trsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold rule-set matcher package
// Shared sizes, command codes, status codes and controller states.
// ----------------------------------------------------------------------------
package trsm_pkg;

   // Store dimensions.
   localparam int MAX_RULES       = 64;
   localparam int MAX_ANTECEDENTS = 16;
   localparam int MAX_ATTRIBUTES  = 256;
   localparam int VALUE_WIDTH     = 32;

   // Field and address widths.
   localparam int RULE_W     = $clog2(MAX_RULES);
   localparam int SLOT_W     = $clog2(MAX_ANTECEDENTS);
   localparam int ATTR_W     = $clog2(MAX_ATTRIBUTES);
   localparam int LEN_W      = $clog2(MAX_ANTECEDENTS + 1);
   localparam int ANT_ADDR_W = RULE_W + SLOT_W;
   localparam int ANT_DEPTH  = MAX_RULES * MAX_ANTECEDENTS;
   localparam int ANT_DATA_W = ATTR_W + 1 + VALUE_WIDTH;

   // Configuration register widths and indices.
   localparam int RULE_CNT_W = 7;
   localparam int ATTR_CNT_W = 9;
   localparam int CSR_DATA_W = 9;
   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_RULE_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTR_COUNT = 1'b1;
   localparam logic [ATTR_CNT_W-1:0] ATTR_COUNT_RESET = ATTR_CNT_W'(256);

   // Result status codes.
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   // Request commands.
   typedef enum logic [1:0] {
      CMD_WRITE_ANT    = 2'd0,
      CMD_WRITE_LEN    = 2'd1,
      CMD_WRITE_SAMPLE = 2'd2,
      CMD_EVALUATE     = 2'd3
   } trsm_cmd_type;

   // Evaluation controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RULE,
      ST_ANT,
      ST_SMP,
      ST_FIRE,
      ST_FINISH,
      ST_ERROR
   } trsm_state_type;

endpackage

>>> design/trsm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module trsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/threshold_rule_set_matcher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold rule-set matcher, top level
// Holds conjunctive threshold rules and one sample, and reports which rules
// the sample satisfies.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel carries commands. Antecedent, rule-length and sample
// writes produce no beat on the rsp_ channel.
// An evaluate command walks the rules in order; req_ready stays low until
// the run has delivered its closing beat into the output register.
// Each firing rule gives one rsp_ beat; the final beat of a run has
// rsp_last set. A run with no firing rule gives a single no-match beat, and
// an antecedent naming an attribute at or beyond attribute_count ends the
// run with a status beat.
// Evaluation steps, from the accepting edge: a rule step per rule visited
// and an end-of-table check, an antecedent memory read and then a sample
// memory read per antecedent checked (a failing range check stops after
// the first), a fire step per firing rule and a closing step (preceded by
// one sending a held match when a range error ends the run), plus any
// receiver stalls. Each antecedent needs two chained memory reads.
// A result waits in the output register while rsp_ready is low; the walk
// pauses only when a new beat must be written and the register is full.
// Reset sets the configuration to its defaults, clears the rule lengths (held
// as valid bits) and controller; antecedent and sample RAMs are not cleared.
// ----------------------------------------------------------------------------
module threshold_rule_set_matcher_top (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel.
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_command,
   input  logic [trsm_pkg::RULE_W-1:0]           req_rule_index,
   input  logic [trsm_pkg::SLOT_W-1:0]           req_slot,
   input  logic [trsm_pkg::ATTR_W-1:0]           req_attribute,
   input  logic                                  req_greater_equal,
   input  logic signed [trsm_pkg::VALUE_WIDTH-1:0] req_threshold,
   input  logic [trsm_pkg::LEN_W-1:0]            req_antecedent_total,
   input  logic signed [trsm_pkg::VALUE_WIDTH-1:0] req_sample_value,
   // Result channel.
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [trsm_pkg::RULE_W-1:0]           rsp_fired_rule,
   output logic                                  rsp_matched,
   output logic                                  rsp_status,
   output logic                                  rsp_last,
   // Configuration write port.
   input  logic                                  csr_write_en,
   input  logic [trsm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [trsm_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   trsm_pkg::trsm_state_type state_ff, state_in;

   logic [trsm_pkg::RULE_CNT_W-1:0] rule_count_ff;
   logic [trsm_pkg::ATTR_CNT_W-1:0] attr_count_ff;
   logic [trsm_pkg::RULE_CNT_W-1:0] rule_limit;
   logic [trsm_pkg::ATTR_CNT_W-1:0] attr_limit;

   logic [trsm_pkg::RULE_CNT_W-1:0] rule_ff, rule_in;
   logic [trsm_pkg::SLOT_W-1:0]     slot_ff, slot_in;
   logic [trsm_pkg::LEN_W-1:0]      len_ff, len_in;
   logic                            ge_ff, ge_in;
   logic [trsm_pkg::VALUE_WIDTH-1:0] thr_ff, thr_in;
   logic                            pend_valid_ff, pend_valid_in;
   logic [trsm_pkg::RULE_W-1:0]     pend_rule_ff, pend_rule_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [trsm_pkg::RULE_W-1:0]     rsp_rule_ff, rsp_rule_in;
   logic                            rsp_matched_ff, rsp_matched_in;
   logic                            rsp_status_ff, rsp_status_in;
   logic                            rsp_last_ff, rsp_last_in;
   logic                            emit;

   logic [trsm_pkg::MAX_RULES-1:0]  len_valid_ff;

   logic                            accept;
   logic                            out_free;

   // Memory ports.
   logic                               ant_wr_en;
   logic [trsm_pkg::ANT_ADDR_W-1:0]    ant_wr_addr;
   logic [trsm_pkg::ANT_DATA_W-1:0]    ant_wr_data;
   logic [trsm_pkg::ANT_ADDR_W-1:0]    ant_rd_addr;
   logic [trsm_pkg::ANT_DATA_W-1:0]    ant_rd_data;
   logic                               len_wr_en;
   logic [trsm_pkg::LEN_W-1:0]         len_wr_data;
   logic [trsm_pkg::LEN_W-1:0]         len_rd_data;
   logic                               smp_wr_en;
   logic [trsm_pkg::VALUE_WIDTH-1:0]   smp_rd_data;

   // Antecedent fields and evaluation terms.
   logic [trsm_pkg::ATTR_W-1:0]        ant_attr;
   logic                               ant_ge;
   logic [trsm_pkg::VALUE_WIDTH-1:0]   ant_thr;
   logic [trsm_pkg::LEN_W-1:0]         rule_len;
   logic                               range_err;
   logic                               holds;
   logic                               last_slot;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Effective limits, saturated to the store sizes.
   assign rule_limit = (rule_count_ff > trsm_pkg::RULE_CNT_W'(trsm_pkg::MAX_RULES)) ?
                       trsm_pkg::RULE_CNT_W'(trsm_pkg::MAX_RULES) : rule_count_ff;
   assign attr_limit = (attr_count_ff > trsm_pkg::ATTR_CNT_W'(trsm_pkg::MAX_ATTRIBUTES)) ?
                       trsm_pkg::ATTR_CNT_W'(trsm_pkg::MAX_ATTRIBUTES) : attr_count_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rule_count_ff <= '0;
         attr_count_ff <= trsm_pkg::ATTR_COUNT_RESET;
      end else if (csr_write_en) begin
         if (csr_index == trsm_pkg::CSR_RULE_COUNT) begin
            rule_count_ff <= csr_write_data[trsm_pkg::RULE_CNT_W-1:0];
         end else begin
            attr_count_ff <= csr_write_data[trsm_pkg::ATTR_CNT_W-1:0];
         end
      end
   end

   // Load commands write straight into the stores.
   assign ant_wr_en   = accept && (req_command == trsm_pkg::CMD_WRITE_ANT);
   assign ant_wr_addr = {req_rule_index, req_slot};
   assign ant_wr_data = {req_attribute, req_greater_equal, req_threshold};
   assign len_wr_en   = accept && (req_command == trsm_pkg::CMD_WRITE_LEN);
   assign len_wr_data =
      (req_antecedent_total > trsm_pkg::LEN_W'(trsm_pkg::MAX_ANTECEDENTS)) ?
      trsm_pkg::LEN_W'(trsm_pkg::MAX_ANTECEDENTS) : req_antecedent_total;
   assign smp_wr_en   = accept && (req_command == trsm_pkg::CMD_WRITE_SAMPLE);

   // Rule lengths read as zero until written.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_valid_ff <= '0;
      end else if (len_wr_en) begin
         len_valid_ff[req_rule_index] <= 1'b1;
      end
   end

   // Read addresses follow the next rule and slot, so the read data always
   // belongs to the current rule and slot registers.
   assign ant_rd_addr = {rule_in[trsm_pkg::RULE_W-1:0], slot_in};

   trsm_ram #(
      .WIDTH (trsm_pkg::ANT_DATA_W),
      .DEPTH (trsm_pkg::ANT_DEPTH)
   ) u_ant_ram (
      .clock   (clock),
      .wr_en   (ant_wr_en),
      .wr_addr (ant_wr_addr),
      .wr_data (ant_wr_data),
      .rd_addr (ant_rd_addr),
      .rd_data (ant_rd_data)
   );

   trsm_ram #(
      .WIDTH (trsm_pkg::LEN_W),
      .DEPTH (trsm_pkg::MAX_RULES)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_wr_en),
      .wr_addr (req_rule_index),
      .wr_data (len_wr_data),
      .rd_addr (rule_in[trsm_pkg::RULE_W-1:0]),
      .rd_data (len_rd_data)
   );

   trsm_ram #(
      .WIDTH (trsm_pkg::VALUE_WIDTH),
      .DEPTH (trsm_pkg::MAX_ATTRIBUTES)
   ) u_smp_ram (
      .clock   (clock),
      .wr_en   (smp_wr_en),
      .wr_addr (req_attribute),
      .wr_data (req_sample_value),
      .rd_addr (ant_attr),
      .rd_data (smp_rd_data)
   );

   // Unpack the antecedent and form the checks.
   assign ant_attr  = ant_rd_data[trsm_pkg::ANT_DATA_W-1 -: trsm_pkg::ATTR_W];
   assign ant_ge    = ant_rd_data[trsm_pkg::VALUE_WIDTH];
   assign ant_thr   = ant_rd_data[trsm_pkg::VALUE_WIDTH-1:0];
   assign rule_len  = len_valid_ff[rule_ff[trsm_pkg::RULE_W-1:0]] ? len_rd_data : '0;
   assign range_err = {1'b0, ant_attr} >= attr_limit;
   assign holds     = ge_ff ? ($signed(smp_rd_data) >= $signed(thr_ff)) :
                              ($signed(smp_rd_data) <  $signed(thr_ff));
   assign last_slot = (trsm_pkg::LEN_W'(slot_ff) + trsm_pkg::LEN_W'(1)) == len_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         trsm_pkg::ST_IDLE: begin
            if (accept && (req_command == trsm_pkg::CMD_EVALUATE)) begin
               state_in = trsm_pkg::ST_RULE;
            end
         end
         trsm_pkg::ST_RULE: begin
            if (rule_ff == rule_limit) begin
               state_in = trsm_pkg::ST_FINISH;
            end else if (rule_len == '0) begin
               state_in = trsm_pkg::ST_FIRE;
            end else begin
               state_in = trsm_pkg::ST_ANT;
            end
         end
         trsm_pkg::ST_ANT: begin
            state_in = range_err ? trsm_pkg::ST_ERROR : trsm_pkg::ST_SMP;
         end
         trsm_pkg::ST_SMP: begin
            if (!holds) begin
               state_in = trsm_pkg::ST_RULE;
            end else if (last_slot) begin
               state_in = trsm_pkg::ST_FIRE;
            end else begin
               state_in = trsm_pkg::ST_ANT;
            end
         end
         trsm_pkg::ST_FIRE: begin
            if (out_free || !pend_valid_ff) begin
               state_in = trsm_pkg::ST_RULE;
            end
         end
         trsm_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = trsm_pkg::ST_IDLE;
            end
         end
         trsm_pkg::ST_ERROR: begin
            if (out_free && !pend_valid_ff) begin
               state_in = trsm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = trsm_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath control and result generation. A firing rule is held back until
   // the next one fires or the walk ends, so that the last flag can be set.
   always_comb begin
      rule_in        = rule_ff;
      slot_in        = slot_ff;
      len_in         = len_ff;
      ge_in          = ge_ff;
      thr_in         = thr_ff;
      pend_valid_in  = pend_valid_ff;
      pend_rule_in   = pend_rule_ff;
      emit           = 1'b0;
      rsp_rule_in    = '0;
      rsp_matched_in = 1'b0;
      rsp_status_in  = trsm_pkg::STATUS_OK;
      rsp_last_in    = 1'b0;
      case (state_ff)
         trsm_pkg::ST_IDLE: begin
            if (accept && (req_command == trsm_pkg::CMD_EVALUATE)) begin
               rule_in       = '0;
               slot_in       = '0;
               pend_valid_in = 1'b0;
            end
         end
         trsm_pkg::ST_RULE: begin
            len_in = rule_len;
         end
         trsm_pkg::ST_ANT: begin
            ge_in  = ant_ge;
            thr_in = ant_thr;
         end
         trsm_pkg::ST_SMP: begin
            if (!holds) begin
               rule_in = rule_ff + trsm_pkg::RULE_CNT_W'(1);
               slot_in = '0;
            end else if (!last_slot) begin
               slot_in = slot_ff + trsm_pkg::SLOT_W'(1);
            end
         end
         trsm_pkg::ST_FIRE: begin
            if (out_free || !pend_valid_ff) begin
               emit           = pend_valid_ff;
               rsp_rule_in    = pend_rule_ff;
               rsp_matched_in = 1'b1;
               pend_valid_in  = 1'b1;
               pend_rule_in   = rule_ff[trsm_pkg::RULE_W-1:0];
               rule_in        = rule_ff + trsm_pkg::RULE_CNT_W'(1);
               slot_in        = '0;
            end
         end
         trsm_pkg::ST_FINISH: begin
            if (out_free) begin
               emit           = 1'b1;
               rsp_rule_in    = pend_valid_ff ? pend_rule_ff : '0;
               rsp_matched_in = pend_valid_ff;
               rsp_last_in    = 1'b1;
               pend_valid_in  = 1'b0;
            end
         end
         trsm_pkg::ST_ERROR: begin
            if (out_free) begin
               emit = 1'b1;
               if (pend_valid_ff) begin
                  rsp_rule_in    = pend_rule_ff;
                  rsp_matched_in = 1'b1;
                  pend_valid_in  = 1'b0;
               end else begin
                  rsp_status_in = trsm_pkg::STATUS_RANGE;
                  rsp_last_in   = 1'b1;
               end
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= trsm_pkg::ST_IDLE;
         rule_ff       <= '0;
         slot_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rule_ff       <= rule_in;
         slot_ff       <= slot_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      ge_ff        <= ge_in;
      thr_ff       <= thr_in;
      pend_rule_ff <= pend_rule_in;
      if (emit) begin
         rsp_rule_ff    <= rsp_rule_in;
         rsp_matched_ff <= rsp_matched_in;
         rsp_status_ff  <= rsp_status_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   assign req_ready      = (state_ff == trsm_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fired_rule = rsp_rule_ff;
   assign rsp_matched    = rsp_matched_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

>>> design/trsm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold rule-set matcher checker
// Port-level properties of the matcher, attached to the top level by bind.
// ----------------------------------------------------------------------------
module trsm_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic [1:0]                            req_command,
   input logic [trsm_pkg::RULE_W-1:0]           req_rule_index,
   input logic [trsm_pkg::SLOT_W-1:0]           req_slot,
   input logic [trsm_pkg::ATTR_W-1:0]           req_attribute,
   input logic                                  req_greater_equal,
   input logic signed [trsm_pkg::VALUE_WIDTH-1:0] req_threshold,
   input logic [trsm_pkg::LEN_W-1:0]            req_antecedent_total,
   input logic signed [trsm_pkg::VALUE_WIDTH-1:0] req_sample_value,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [trsm_pkg::RULE_W-1:0]           rsp_fired_rule,
   input logic                                  rsp_matched,
   input logic                                  rsp_status,
   input logic                                  rsp_last,
   input logic                                  csr_write_en,
   input logic [trsm_pkg::CSR_IDX_W-1:0]        csr_index,
   input logic [trsm_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   // A stalled result beat holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fired_rule) &&
      $stable(rsp_matched) && $stable(rsp_status) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   // No-match and error beats always close the run and name rule zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_matched |-> rsp_last && rsp_fired_rule == '0)
      else $error("non-matching beat is not a closing beat");

   // A range error never names a rule.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == trsm_pkg::STATUS_RANGE |-> !rsp_matched)
      else $error("error beat marked as a match");

   // A match always carries an ok status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_matched |-> rsp_status == trsm_pkg::STATUS_OK)
      else $error("matching beat with error status");

   // While a run's non-final beat waits, the run is still busy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request accepted before the run closed");

endmodule

bind threshold_rule_set_matcher_top trsm_checker u_trsm_checker (.*);

>>> test/tb_threshold_rule_set_matcher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold rule-set matcher testbench
// Loads rules, antecedents and sample values through the request channel and
// issues evaluations under several register settings. A mirror of the rule
// and sample stores predicts every result beat, and a monitor compares
// each accepted result beat with the oldest prediction. Both channels idle in
// random bursts, and one phase holds the receiver off so that the input stalls.
// ----------------------------------------------------------------------------
module tb_threshold_rule_set_matcher_top;

   localparam int CLOCK_HALF    = 6;
   localparam int RESET_CYCLES  = 11;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ACTIONS = 5;
   localparam int HOLD_PHASE    = 3;

   // One request beat, every field at the width of its port.
   typedef struct {
      trsm_pkg::trsm_cmd_type                  command;
      logic [trsm_pkg::RULE_W-1:0]             rule_index;
      logic [trsm_pkg::SLOT_W-1:0]             slot;
      logic [trsm_pkg::ATTR_W-1:0]             attribute;
      logic                                    greater_equal;
      logic signed [trsm_pkg::VALUE_WIDTH-1:0] threshold;
      logic [trsm_pkg::LEN_W-1:0]              antecedent_total;
      logic signed [trsm_pkg::VALUE_WIDTH-1:0] sample_value;
   } command_beat_type;

   // One result beat.
   typedef struct {
      logic [trsm_pkg::RULE_W-1:0] fired_rule;
      logic                        matched;
      logic                        status;
      logic                        last;
   } match_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                    req_valid            = 1'b0;
   logic                                    req_ready;
   logic [1:0]                              req_command          = '0;
   logic [trsm_pkg::RULE_W-1:0]             req_rule_index       = '0;
   logic [trsm_pkg::SLOT_W-1:0]             req_slot             = '0;
   logic [trsm_pkg::ATTR_W-1:0]             req_attribute        = '0;
   logic                                    req_greater_equal    = 1'b0;
   logic signed [trsm_pkg::VALUE_WIDTH-1:0] req_threshold        = '0;
   logic [trsm_pkg::LEN_W-1:0]              req_antecedent_total = '0;
   logic signed [trsm_pkg::VALUE_WIDTH-1:0] req_sample_value     = '0;

   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [trsm_pkg::RULE_W-1:0] rsp_fired_rule;
   logic                        rsp_matched;
   logic                        rsp_status;
   logic                        rsp_last;

   logic                            csr_write_en   = 1'b0;
   logic [trsm_pkg::CSR_IDX_W-1:0]  csr_index      = '0;
   logic [trsm_pkg::CSR_DATA_W-1:0] csr_write_data = '0;

   threshold_rule_set_matcher_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_rule_index       (req_rule_index),
      .req_slot             (req_slot),
      .req_attribute        (req_attribute),
      .req_greater_equal    (req_greater_equal),
      .req_threshold        (req_threshold),
      .req_antecedent_total (req_antecedent_total),
      .req_sample_value     (req_sample_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_fired_rule       (rsp_fired_rule),
      .rsp_matched          (rsp_matched),
      .rsp_status           (rsp_status),
      .rsp_last             (rsp_last),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // Beats waiting to be driven, and result beats waiting to arrive.
   command_beat_type pending_commands[$];
   match_beat_type   expected_matches[$];

   // Mirror of the block's stores and registers, updated as beats are driven.
   logic [trsm_pkg::ATTR_W-1:0]             ant_attr_mirror [trsm_pkg::ANT_DEPTH];
   logic                                    ant_ge_mirror   [trsm_pkg::ANT_DEPTH];
   logic signed [trsm_pkg::VALUE_WIDTH-1:0] ant_thr_mirror  [trsm_pkg::ANT_DEPTH];
   logic [trsm_pkg::LEN_W-1:0]              rule_len_mirror [trsm_pkg::MAX_RULES];
   logic signed [trsm_pkg::VALUE_WIDTH-1:0] sample_mirror   [trsm_pkg::MAX_ATTRIBUTES];
   logic [trsm_pkg::RULE_CNT_W-1:0]         rule_count_mirror = '0;
   logic [trsm_pkg::ATTR_CNT_W-1:0]         attr_count_mirror = trsm_pkg::ATTR_COUNT_RESET;

   // What the stimulus has written so far, so that no unwritten entry is read.
   bit                                      ant_loaded    [trsm_pkg::ANT_DEPTH];
   bit                                      sample_loaded [trsm_pkg::MAX_ATTRIBUTES];
   logic signed [trsm_pkg::VALUE_WIDTH-1:0] sample_plan   [trsm_pkg::MAX_ATTRIBUTES];

   int mismatch_count = 0;
   int cycle_count    = 0;
   bit idle_enabled   = 1'b1;
   int hold_requests  = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   int send_gap       = 0;
   int recv_gap       = 0;
   logic req_taken    = 1'b0;

   // ------------------------------------------------------------------------
   // Queue helpers
   // ------------------------------------------------------------------------

   function automatic void add_command(input command_beat_type beat);
      pending_commands.insert(pending_commands.size(), beat);
   endfunction

   function automatic void add_expected(input match_beat_type beat);
      expected_matches.insert(expected_matches.size(), beat);
   endfunction

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Applies a load beat to the mirror, or walks the rules for an evaluate
   // beat and queues the result beats it must produce.
   function automatic void predict_command(input command_beat_type beat);
      int             addr;
      int             rules_walked;
      int             attrs_valid;
      int             fired_total;
      bit             fires;
      bit             halted;
      logic signed [trsm_pkg::VALUE_WIDTH-1:0] value;
      match_beat_type result;
      addr = int'(beat.rule_index) * trsm_pkg::MAX_ANTECEDENTS + int'(beat.slot);
      case (beat.command)
         trsm_pkg::CMD_WRITE_ANT: begin
            ant_attr_mirror[addr] = beat.attribute;
            ant_ge_mirror[addr]   = beat.greater_equal;
            ant_thr_mirror[addr]  = beat.threshold;
         end
         trsm_pkg::CMD_WRITE_LEN: begin
            rule_len_mirror[beat.rule_index] =
               (beat.antecedent_total > trsm_pkg::MAX_ANTECEDENTS) ?
               trsm_pkg::LEN_W'(trsm_pkg::MAX_ANTECEDENTS) : beat.antecedent_total;
         end
         trsm_pkg::CMD_WRITE_SAMPLE: begin
            sample_mirror[beat.attribute] = beat.sample_value;
         end
         default: begin
            rules_walked = (rule_count_mirror > trsm_pkg::MAX_RULES) ?
               trsm_pkg::MAX_RULES : int'(rule_count_mirror);
            attrs_valid  = (attr_count_mirror > trsm_pkg::MAX_ATTRIBUTES) ?
               trsm_pkg::MAX_ATTRIBUTES : int'(attr_count_mirror);
            fired_total  = 0;
            halted       = 1'b0;
            for (int r = 0; r < rules_walked && !halted; r++) begin
               fires = 1'b1;
               for (int s = 0; s < int'(rule_len_mirror[r]) && fires && !halted; s++) begin
                  addr = r * trsm_pkg::MAX_ANTECEDENTS + s;
                  if (int'(ant_attr_mirror[addr]) >= attrs_valid) begin
                     halted = 1'b1;
                  end else begin
                     value = sample_mirror[ant_attr_mirror[addr]];
                     if (ant_ge_mirror[addr] ? (value < ant_thr_mirror[addr]) :
                                               (value >= ant_thr_mirror[addr])) begin
                        fires = 1'b0;
                     end
                  end
               end
               if (fires && !halted) begin
                  result.fired_rule = trsm_pkg::RULE_W'(r);
                  result.matched    = 1'b1;
                  result.status     = trsm_pkg::STATUS_OK;
                  result.last       = 1'b0;
                  add_expected(result);
                  fired_total++;
               end
            end
            // A range error or an empty run closes with a beat of its own.
            if (halted || fired_total == 0) begin
               result.fired_rule = '0;
               result.matched    = 1'b0;
               result.status     = halted ? trsm_pkg::STATUS_RANGE : trsm_pkg::STATUS_OK;
               result.last       = 1'b1;
               add_expected(result);
            end else begin
               expected_matches[expected_matches.size() - 1].last = 1'b1;
            end
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus building
   // ------------------------------------------------------------------------

   // A beat with every field random; callers then set what the command uses.
   function automatic command_beat_type random_beat(input trsm_pkg::trsm_cmd_type command);
      command_beat_type beat;
      beat.command          = command;
      beat.rule_index       = trsm_pkg::RULE_W'($urandom);
      beat.slot             = trsm_pkg::SLOT_W'($urandom);
      beat.attribute        = trsm_pkg::ATTR_W'($urandom);
      beat.greater_equal    = 1'($urandom);
      beat.threshold        = $urandom;
      beat.antecedent_total = trsm_pkg::LEN_W'($urandom);
      beat.sample_value     = $urandom;
      return beat;
   endfunction

   function automatic logic signed [trsm_pkg::VALUE_WIDTH-1:0] pick_sample_value();
      case ($urandom_range(0, 7))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return $signed($urandom_range(0, 255)) - 128;
         default: return $urandom;
      endcase
   endfunction

   function automatic void queue_sample(input int attr, input logic signed [31:0] value);
      command_beat_type beat;
      beat              = random_beat(trsm_pkg::CMD_WRITE_SAMPLE);
      beat.attribute    = trsm_pkg::ATTR_W'(attr);
      beat.sample_value = value;
      add_command(beat);
      sample_loaded[attr] = 1'b1;
      sample_plan[attr]   = value;
   endfunction

   function automatic void ensure_sample(input int attr);
      if (!sample_loaded[attr]) begin
         queue_sample(attr, pick_sample_value());
      end
   endfunction

   // The sample entry an antecedent names is always written before it.
   function automatic void queue_antecedent(input int r, input int s, input int attr,
                                            input logic ge, input logic signed [31:0] thr);
      command_beat_type beat;
      ensure_sample(attr);
      beat               = random_beat(trsm_pkg::CMD_WRITE_ANT);
      beat.rule_index    = trsm_pkg::RULE_W'(r);
      beat.slot          = trsm_pkg::SLOT_W'(s);
      beat.attribute     = trsm_pkg::ATTR_W'(attr);
      beat.greater_equal = ge;
      beat.threshold     = thr;
      add_command(beat);
      ant_loaded[r * trsm_pkg::MAX_ANTECEDENTS + s] = 1'b1;
   endfunction

   // Most antecedents are built to hold, often right at the threshold.
   function automatic void queue_random_antecedent(input int r, input int s);
      int   attr;
      logic ge;
      logic signed [trsm_pkg::VALUE_WIDTH-1:0] thr;
      logic signed [trsm_pkg::VALUE_WIDTH-1:0] base;
      attr = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) : $urandom_range(0, 255);
      ensure_sample(attr);
      base = sample_plan[attr];
      case ($urandom_range(0, 7))
         0, 1: begin
            ge  = 1'b1;
            thr = base;
         end
         2: begin
            ge  = 1'b1;
            thr = base - 1;
         end
         3, 4: begin
            ge  = 1'b0;
            thr = base + 1;
         end
         5: begin
            ge  = 1'b0;
            thr = base;
         end
         default: begin
            ge  = 1'($urandom);
            thr = $urandom;
         end
      endcase
      queue_antecedent(r, s, attr, ge, thr);
   endfunction

   // Every slot that the new length brings into use is written first.
   function automatic void queue_length(input int r, input int total);
      command_beat_type beat;
      int               used;
      used = (total > trsm_pkg::MAX_ANTECEDENTS) ? trsm_pkg::MAX_ANTECEDENTS : total;
      for (int s = 0; s < used; s++) begin
         if (!ant_loaded[r * trsm_pkg::MAX_ANTECEDENTS + s]) begin
            queue_random_antecedent(r, s);
         end
      end
      beat                  = random_beat(trsm_pkg::CMD_WRITE_LEN);
      beat.rule_index       = trsm_pkg::RULE_W'(r);
      beat.antecedent_total = trsm_pkg::LEN_W'(total);
      add_command(beat);
   endfunction

   function automatic void queue_evaluate();
      add_command(random_beat(trsm_pkg::CMD_EVALUATE));
   endfunction

   // A complete rule: fresh antecedents, then its length.
   function automatic void queue_rule(input int r);
      int total;
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 12)      total = $urandom_range(0, 3);
      else if (pick < 17) total = $urandom_range(4, 8);
      else if (pick < 19) total = trsm_pkg::MAX_ANTECEDENTS;
      else                total = $urandom_range(trsm_pkg::MAX_ANTECEDENTS + 1, 31);
      for (int s = 0; s < total && s < trsm_pkg::MAX_ANTECEDENTS; s++) begin
         queue_random_antecedent(r, s);
      end
      queue_length(r, total);
   endfunction

   function automatic void queue_random_phase(input int actions);
      int walked;
      int r;
      int pick;
      walked = (rule_count_mirror > trsm_pkg::MAX_RULES) ?
               trsm_pkg::MAX_RULES : int'(rule_count_mirror);
      for (int n = 0; n < actions; n++) begin
         r = ($urandom_range(0, 3) != 0 && walked > 0) ?
             $urandom_range(0, walked - 1) : $urandom_range(0, trsm_pkg::MAX_RULES - 1);
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            queue_rule(r);
            if ($urandom_range(0, 1) == 0) queue_evaluate();
         end else if (pick < 65) begin
            queue_evaluate();
         end else if (pick < 80) begin
            queue_sample(($urandom_range(0, 2) != 0) ? $urandom_range(0, 7) :
                         $urandom_range(0, 255), pick_sample_value());
         end else if (pick < 90) begin
            queue_random_antecedent(r, $urandom_range(0, trsm_pkg::MAX_ANTECEDENTS - 1));
         end else begin
            // Loose writes with random fields, still keeping reads defined.
            case ($urandom_range(0, 2))
               0:       queue_antecedent($urandom_range(0, 63), $urandom_range(0, 15),
                                         $urandom_range(0, 255), 1'($urandom), $urandom);
               1:       queue_length($urandom_range(0, 63), $urandom_range(0, 31));
               default: queue_sample($urandom_range(0, 255), $urandom);
            endcase
         end
      end
   endfunction

   // ------------------------------------------------------------------------
   // Control helpers
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // Waits until every beat is driven and every prediction has arrived.
   task automatic drain_all();
      do @(posedge clock);
      while (pending_commands.size() != 0 || req_valid || expected_matches.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [trsm_pkg::CSR_IDX_W-1:0] index,
                                 input logic [trsm_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= index;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      if (index == trsm_pkg::CSR_RULE_COUNT) begin
         rule_count_mirror = data[trsm_pkg::RULE_CNT_W-1:0];
      end else begin
         attr_count_mirror = data[trsm_pkg::ATTR_CNT_W-1:0];
      end
   endtask

   // ------------------------------------------------------------------------
   // Request driver: one beat held until accepted, random gaps between beats.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
   end

   always @(negedge clock) begin
      command_beat_type beat;
      logic             next_valid;
      next_valid = req_valid;
      if (req_valid && req_taken) next_valid = 1'b0;
      if (!next_valid && !reset) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 19) - 1;
         end else if (pending_commands.size() > 0) begin
            beat = pending_commands.pop_front();
            predict_command(beat);
            next_valid            = 1'b1;
            req_command          <= beat.command;
            req_rule_index       <= beat.rule_index;
            req_slot             <= beat.slot;
            req_attribute        <= beat.attribute;
            req_greater_equal    <= beat.greater_equal;
            req_threshold        <= beat.threshold;
            req_antecedent_total <= beat.antecedent_total;
            req_sample_value     <= beat.sample_value;
         end
      end
      req_valid <= next_valid;
   end

   // ------------------------------------------------------------------------
   // Result receiver: random stall bursts, and a long hold-off on request.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      logic next_ready;
      if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         next_ready = 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         next_ready = 1'b0;
      end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
         recv_gap   = $urandom_range(1, 19) - 1;
         next_ready = 1'b0;
      end else begin
         next_ready = 1'b1;
      end
      rsp_ready <= next_ready;
   end

   // ------------------------------------------------------------------------
   // Result monitor: each accepted beat against the oldest prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      match_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_matches.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing predicted (rule %0d)",
                                      rsp_fired_rule));
         end else begin
            want = expected_matches.pop_front();
            if (rsp_fired_rule !== want.fired_rule)
               report_mismatch($sformatf("fired_rule got %0d, want %0d",
                                         rsp_fired_rule, want.fired_rule));
            if (rsp_matched !== want.matched)
               report_mismatch($sformatf("matched got %0d, want %0d (rule %0d)",
                                         rsp_matched, want.matched, want.fired_rule));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status field got %0d, want %0d",
                                         rsp_status, want.status));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last got %0d, want %0d (rule %0d)",
                                         rsp_last, want.last, want.fired_rule));
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence of phases
   // ------------------------------------------------------------------------
   initial begin
      logic [trsm_pkg::CSR_DATA_W-1:0] rule_data;
      logic [trsm_pkg::CSR_DATA_W-1:0] attr_data;
      for (int r = 0; r < trsm_pkg::MAX_RULES; r++) rule_len_mirror[r] = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // With the reset settings no rule is walked, so a lone no-match beat.
      queue_evaluate();
      drain_all();

      // Directed rules: empty rule, exact thresholds at both extremes, the
      // top attribute and slot, and a length that saturates.
      write_register(trsm_pkg::CSR_RULE_COUNT, 9'd4);
      write_register(trsm_pkg::CSR_ATTR_COUNT, 9'd256);
      queue_sample(0, 32'sh7FFF_FFFF);
      queue_sample(1, 32'sh8000_0000);
      queue_sample(255, '0);
      queue_length(0, 0);
      queue_antecedent(1, 0, 0, 1'b1, 32'sh7FFF_FFFF);
      queue_antecedent(1, 1, 1, 1'b0, 32'sh8000_0000);
      queue_length(1, 2);
      queue_antecedent(2, 0, 1, 1'b1, 32'sh8000_0000);
      queue_antecedent(2, 1, 255, 1'b0, 32'sd1);
      queue_length(2, 2);
      queue_antecedent(3, 15, 0, 1'b0, 32'sh8000_0000);
      queue_length(3, 31);
      queue_evaluate();
      drain_all();

      // Attribute 255 now lies out of range after rule 0 has fired.
      write_register(trsm_pkg::CSR_ATTR_COUNT, 9'd2);
      queue_evaluate();
      drain_all();

      // A zero attribute count makes the first checked antecedent an error.
      write_register(trsm_pkg::CSR_ATTR_COUNT, 9'd0);
      queue_evaluate();
      drain_all();

      // Oversized counts saturate to the store sizes.
      write_register(trsm_pkg::CSR_RULE_COUNT, 9'h1FF);
      write_register(trsm_pkg::CSR_ATTR_COUNT, 9'h1FF);
      queue_evaluate();
      drain_all();

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               rule_data = 9'd64;
               attr_data = 9'd256;
            end
            1: begin
               rule_data = 9'd1;
               attr_data = 9'd1;
            end
            2: begin
               rule_data = trsm_pkg::CSR_DATA_W'($urandom);
               attr_data = trsm_pkg::CSR_DATA_W'($urandom);
            end
            HOLD_PHASE: begin
               rule_data = 9'd16;
               attr_data = 9'd256;
            end
            4: begin
               rule_data = trsm_pkg::CSR_DATA_W'($urandom_range(0, 64));
               attr_data = trsm_pkg::CSR_DATA_W'($urandom_range(1, 256));
            end
            5: begin
               rule_data = 9'h1C0;
               attr_data = 9'h1FF;
            end
            6: begin
               rule_data = trsm_pkg::CSR_DATA_W'($urandom_range(0, 511));
               attr_data = trsm_pkg::CSR_DATA_W'($urandom_range(200, 256));
            end
            default: begin
               rule_data = 9'd32;
               attr_data = 9'd256;
            end
         endcase
         write_register(trsm_pkg::CSR_RULE_COUNT, rule_data);
         write_register(trsm_pkg::CSR_ATTR_COUNT, attr_data);
         if (phase == HOLD_PHASE) begin
            // Two evaluations fill the output register and stall the input
            // while the receiver holds off and further beats keep coming.
            hold_requests++;
            queue_evaluate();
            queue_evaluate();
         end
         if (phase == RANDOM_PHASES - 1) begin
            idle_enabled = 1'b0;
            send_gap     = 0;
            recv_gap     = 0;
         end
         queue_random_phase(PHASE_ACTIONS);
         drain_all();
      end

      if (mismatch_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
